FILE: design/box_wall_impulse_response_macros.svh
// Assertion macros for the box wall impulse response block.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef BOX_WALL_IMPULSE_RESPONSE_MACROS_SVH
`define BOX_WALL_IMPULSE_RESPONSE_MACROS_SVH

// same-cycle implication
`define BWIR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BWIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bwir_pkg.sv
// Shared types, codes and helpers for the box wall impulse response block.
// No dependencies.
package bwir_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FX_ONE    = 1 << FRAC_BITS;
  localparam int DIV_BITS  = 64;

  typedef logic signed [31:0] fx_t;

  localparam logic [2:0] KIND_POSE = 3'd0;
  localparam logic [2:0] KIND_VEL  = 3'd1;
  localparam logic [2:0] KIND_INV0 = 3'd2;
  localparam logic [2:0] KIND_INV1 = 3'd3;
  localparam logic [2:0] KIND_INV2 = 3'd4;
  localparam logic [2:0] KIND_VERT = 3'd5;

  localparam logic [2:0] WALL_NONE = 3'd0;
  localparam logic [2:0] WALL_XMIN = 3'd1;
  localparam logic [2:0] WALL_XMAX = 3'd2;
  localparam logic [2:0] WALL_YMIN = 3'd3;
  localparam logic [2:0] WALL_YMAX = 3'd4;
  localparam logic [2:0] WALL_ZMIN = 3'd5;
  localparam logic [2:0] WALL_ZMAX = 3'd6;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_AWAY    = 2'd1;
  localparam logic [1:0] ST_IMPULSE = 2'd2;

  localparam logic [2:0] CFG_MIN_X = 3'd0;
  localparam logic [2:0] CFG_MAX_X = 3'd1;
  localparam logic [2:0] CFG_MIN_Y = 3'd2;
  localparam logic [2:0] CFG_MAX_Y = 3'd3;
  localparam logic [2:0] CFG_MIN_Z = 3'd4;
  localparam logic [2:0] CFG_MAX_Z = 3'd5;
  localparam logic [2:0] CFG_REST  = 3'd6;

  typedef struct packed {
    logic             found;
    logic [2:0]       wall;
    fx_t  [2:0]       cp;
    fx_t  [2:0]       pos;
    fx_t  [2:0]       vel;
    logic [30:0]      mass;
    fx_t  [8:0]       inv;
  } job_t;

  function automatic fx_t sat32(input logic signed [65:0] x);
    fx_t r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

FILE: design/bwir_front.sv
// Front end: takes body items, holds body data and finds the first wall contact.
// Hands a complete body job to the queue on the final vertex. Uses bwir_pkg.
module bwir_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_kind,
  input  logic signed [31:0]        in_vx,
  input  logic signed [31:0]        in_vy,
  input  logic signed [31:0]        in_vz,
  input  logic [30:0]               in_body_mass,
  input  logic                      in_final_vertex,
  input  bwir_pkg::fx_t [2:0]       box_lo,
  input  bwir_pkg::fx_t [2:0]       box_hi,
  output logic                      job_valid,
  input  logic                      job_ready,
  output bwir_pkg::job_t            job
);

  bwir_pkg::fx_t [2:0] pos_r, vel_r, cp_r, cp_nxt, v;
  bwir_pkg::fx_t [8:0] inv_r;
  logic [30:0]         mass_r;
  logic                found_r, found_nxt, acc;
  logic [2:0]          wall_r, wall_nxt, hit;

  assign in_stall = !job_ready;
  assign acc      = in_valid && job_ready;
  assign v[0] = in_vx;
  assign v[1] = in_vy;
  assign v[2] = in_vz;

  // lower axis wins, min wall before max wall
  always_comb begin
    hit = bwir_pkg::WALL_NONE;
    for (int i = 2; i >= 0; i--) begin
      if (v[i] <= box_lo[i]) begin
        hit = 3'(2 * i + 1);
      end else if (v[i] >= box_hi[i]) begin
        hit = 3'(2 * i + 2);
      end
    end
  end

  always_comb begin
    found_nxt = found_r;
    wall_nxt  = wall_r;
    cp_nxt    = cp_r;
    if (acc && in_kind == bwir_pkg::KIND_POSE) begin
      found_nxt = 1'b0;
      wall_nxt  = bwir_pkg::WALL_NONE;
      cp_nxt    = '0;
    end else if (acc && in_kind == bwir_pkg::KIND_VERT && !found_r &&
                 hit != bwir_pkg::WALL_NONE) begin
      found_nxt = 1'b1;
      wall_nxt  = hit;
      cp_nxt    = v;
    end
  end

  assign job_valid = acc && in_kind == bwir_pkg::KIND_VERT && in_final_vertex;
  assign job = '{found: found_nxt, wall: wall_nxt, cp: cp_nxt, pos: pos_r,
                 vel: vel_r, mass: mass_r, inv: inv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      wall_r  <= bwir_pkg::WALL_NONE;
      cp_r    <= '0;
    end else if (job_valid) begin
      found_r <= 1'b0;
      wall_r  <= bwir_pkg::WALL_NONE;
      cp_r    <= '0;
    end else begin
      found_r <= found_nxt;
      wall_r  <= wall_nxt;
      cp_r    <= cp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      case (in_kind)
        bwir_pkg::KIND_POSE: begin
          pos_r  <= v;
          mass_r <= in_body_mass;
        end
        bwir_pkg::KIND_VEL:  vel_r <= v;
        bwir_pkg::KIND_INV0: inv_r[2:0] <= v;
        bwir_pkg::KIND_INV1: inv_r[5:3] <= v;
        bwir_pkg::KIND_INV2: inv_r[8:6] <= v;
        default: ;
      endcase
    end
  end

endmodule

FILE: design/bwir_fifo.sv
// Two-entry job queue between front and back ends.
// Uses bwir_pkg for the job type.
module bwir_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           push_ready,
  input  bwir_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop,
  output bwir_pkg::job_t pop_data
);

  bwir_pkg::job_t mem_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r;

  assign push_ready = count_r != 2'd2;
  assign pop_valid  = count_r != 2'd0;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: design/bwir_div.sv
// Radix-2 restoring divider, signed, truncating; one quotient bit a cycle.
// Uses bwir_pkg for the width.
module bwir_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [bwir_pkg::DIV_BITS-1:0] num,
  input  logic signed [bwir_pkg::DIV_BITS-1:0] den,
  output logic                                 done,
  output logic signed [bwir_pkg::DIV_BITS-1:0] quo
);

  localparam int W = bwir_pkg::DIV_BITS;

  logic [W-1:0]         quo_r, rem_r, dmag_r, rem_sh;
  logic                 neg_r, busy_r, done_r;
  logic [$clog2(W):0]   cnt_r;

  assign rem_sh = {rem_r[W-2:0], quo_r[W-1]};
  assign done   = done_r;
  assign quo    = neg_r ? -$signed(quo_r) : $signed(quo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ($clog2(W) + 1)'(W);
        rem_r  <= '0;
        quo_r  <= num[W-1] ? W'(-num) : W'(num);
        dmag_r <= den[W-1] ? W'(-den) : W'(den);
        neg_r  <= num[W-1] ^ den[W-1];
      end else if (busy_r) begin
        if (rem_sh >= dmag_r) begin
          rem_r <= rem_sh - dmag_r;
          quo_r <= {quo_r[W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/bwir_back.sv
// Back end: sequencer that works out the impulse response of one queued body
// on a shared multiplier and the bwir_div divider. Uses bwir_pkg.
module bwir_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_pop,
  input  bwir_pkg::job_t      job,
  input  logic [16:0]         restitution,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [2:0]          out_wall,
  output logic signed [31:0]  out_dlin_x,
  output logic signed [31:0]  out_dlin_y,
  output logic signed [31:0]  out_dlin_z,
  output logic signed [31:0]  out_dang_x,
  output logic signed [31:0]  out_dang_y,
  output logic signed [31:0]  out_dang_z
);

  localparam int F = bwir_pkg::FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_CLASS, S_BMUL, S_BACC, S_CMUL, S_CACC, S_NMUL, S_NUM,
    S_INVM, S_INVW, S_DEN, S_IMPW, S_QST, S_QW, S_DMUL, S_FIN
  } state_t;

  state_t                state_r;
  logic [1:0]            i_r, j_r, ax, ax1, ax2;
  logic                  nneg, load, div_start, div_done;
  bwir_pkg::fx_t [2:0]   r_r, b_r, dang_r, a_vec, rn, dl;
  bwir_pkg::fx_t         imp_r, q_r, dl1;
  logic signed [65:0]    p_r, num_r, prod, p_fsh;
  logic signed [49:0]    acc_r, acc_nxt, c_val;
  logic signed [49:0]    d_r;
  logic signed [33:0]    invm_r;
  logic signed [32:0]    vn_r, vn, ma, mb;
  logic signed [50:0]    den_c;
  logic signed [33:0]    vyn;
  logic signed [37:0]    vyn10;
  logic signed [63:0]    div_num, div_den, div_quo;
  logic [1:0]            status_r;
  logic                  out_valid_r;
  logic [1:0]            o_status_r;
  logic [2:0]            o_wall_r;
  bwir_pkg::fx_t [2:0]   o_dlin_r, o_dang_r;

  always_comb begin
    case (job.wall) inside
      bwir_pkg::WALL_XMIN, bwir_pkg::WALL_XMAX: begin
        ax = 2'd0; ax1 = 2'd1; ax2 = 2'd2;
      end
      bwir_pkg::WALL_YMIN, bwir_pkg::WALL_YMAX: begin
        ax = 2'd1; ax1 = 2'd2; ax2 = 2'd0;
      end
      default: begin
        ax = 2'd2; ax1 = 2'd0; ax2 = 2'd1;
      end
    endcase
  end

  // normal is +1 on odd wall codes, -1 on even ones
  assign nneg = !job.wall[0];
  assign vn   = nneg ? -33'(job.vel[ax]) : 33'(job.vel[ax]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rn[i] = bwir_pkg::sat32(-66'(r_r[i]));
    end
    a_vec = '0;
    case (ax)
      2'd0: begin
        a_vec[1] = nneg ? rn[2] : r_r[2];
        a_vec[2] = nneg ? r_r[1] : rn[1];
      end
      2'd1: begin
        a_vec[0] = nneg ? r_r[2] : rn[2];
        a_vec[2] = nneg ? rn[0] : r_r[0];
      end
      default: begin
        a_vec[0] = nneg ? rn[1] : r_r[1];
        a_vec[1] = nneg ? r_r[0] : rn[0];
      end
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_BMUL: begin
        ma = 33'(job.inv[4'(i_r) * 4'd3 + 4'(j_r)]);
        mb = 33'(a_vec[j_r]);
      end
      S_CMUL: begin
        ma = 33'(j_r[0] ? b_r[ax2] : b_r[ax1]);
        mb = 33'(j_r[0] ? r_r[ax1] : r_r[ax2]);
      end
      S_NMUL: begin
        ma = $signed(33'(restitution) + (33'(1) << F));
        mb = vn_r;
      end
      S_DMUL: begin
        ma = 33'(imp_r);
        mb = 33'(b_r[j_r]);
      end
      default: ;
    endcase
    prod = 66'(ma) * 66'(mb);
  end

  assign p_fsh   = p_r >>> F;
  assign acc_nxt = acc_r + 50'(p_fsh);
  assign c_val   = acc_r - 50'(p_fsh);
  assign den_c   = 51'(invm_r) + 51'(d_r);

  always_comb begin
    div_num = '0;
    div_den = $signed({33'b0, job.mass});
    div_start = 1'b0;
    case (state_r)
      S_INVM: begin
        div_num   = 64'sd1 <<< (2 * F);
        div_start = job.mass != '0;
      end
      S_DEN: begin
        div_num   = 64'(num_r);
        div_den   = 64'(den_c);
        div_start = den_c != '0;
      end
      S_QST: begin
        div_num   = 64'(imp_r) <<< F;
        div_start = job.mass != '0;
      end
      default: ;
    endcase
  end

  bwir_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // linear change and floor resting rule
  always_comb begin
    dl = '0;
    dl[ax] = nneg ? bwir_pkg::sat32(-66'(q_r)) : q_r;
    vyn   = 34'(job.vel[1]) + 34'(dl[1]);
    vyn10 = (38'(vyn) <<< 3) + (38'(vyn) <<< 1);
    dl1   = dl[1];
    if (job.wall == bwir_pkg::WALL_YMIN && vyn > 0 && vyn10 < 38'(bwir_pkg::FX_ONE)) begin
      dl1 = bwir_pkg::sat32(66'(dl[1]) - 66'(vyn));
    end
  end

  assign load    = state_r == S_FIN && (!out_valid_r || !out_stall);
  assign job_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            state_r <= S_CLASS;
          end
        end
        S_CLASS: begin
          if (!job.found || job.wall == bwir_pkg::WALL_NONE) begin
            status_r <= bwir_pkg::ST_NONE;
            state_r  <= S_FIN;
          end else if (vn > 0) begin
            status_r <= bwir_pkg::ST_AWAY;
            state_r  <= S_FIN;
          end else begin
            status_r <= bwir_pkg::ST_IMPULSE;
            for (int i = 0; i < 3; i++) begin
              r_r[i] <= bwir_pkg::sat32(66'(job.cp[i]) - 66'(job.pos[i]));
            end
            vn_r    <= vn;
            acc_r   <= '0;
            i_r     <= 2'd0;
            j_r     <= 2'd0;
            state_r <= S_BMUL;
          end
        end
        S_BMUL: begin
          p_r     <= prod;
          state_r <= S_BACC;
        end
        S_BACC: begin
          if (i_r == 2'd3) begin
            // angular pass: three products of impulse and b, scaled as they land
            dang_r[j_r] <= bwir_pkg::sat32(p_fsh);
            if (j_r == 2'd2) begin
              state_r <= S_FIN;
            end else begin
              j_r     <= j_r + 2'd1;
              state_r <= S_DMUL;
            end
          end else if (j_r == 2'd2) begin
            b_r[i_r] <= bwir_pkg::sat32(66'(acc_nxt));
            acc_r    <= '0;
            j_r      <= 2'd0;
            if (i_r == 2'd2) begin
              state_r <= S_CMUL;
            end else begin
              i_r     <= i_r + 2'd1;
              state_r <= S_BMUL;
            end
          end else begin
            acc_r   <= acc_nxt;
            j_r     <= j_r + 2'd1;
            state_r <= S_BMUL;
          end
        end
        S_CMUL: begin
          p_r     <= prod;
          state_r <= S_CACC;
        end
        S_CACC: begin
          if (j_r == 2'd0) begin
            acc_r   <= 50'(p_fsh);
            j_r     <= 2'd1;
            state_r <= S_CMUL;
          end else begin
            d_r     <= nneg ? -c_val : c_val;
            state_r <= S_NMUL;
          end
        end
        S_NMUL: begin
          p_r     <= prod;
          state_r <= S_NUM;
        end
        S_NUM: begin
          num_r   <= -p_r;
          state_r <= S_INVM;
        end
        S_INVM: begin
          if (job.mass == '0) begin
            invm_r  <= 34'sd2147483647;
            state_r <= S_DEN;
          end else begin
            state_r <= S_INVW;
          end
        end
        S_INVW: begin
          if (div_done) begin
            invm_r  <= div_quo[33:0];
            state_r <= S_DEN;
          end
        end
        S_DEN: begin
          if (den_c == '0) begin
            imp_r   <= '0;
            state_r <= S_QST;
          end else begin
            state_r <= S_IMPW;
          end
        end
        S_IMPW: begin
          if (div_done) begin
            imp_r   <= bwir_pkg::sat32(66'(div_quo));
            state_r <= S_QST;
          end
        end
        S_QST: begin
          j_r <= 2'd0;
          if (job.mass == '0) begin
            q_r <= (imp_r > 0) ? 32'sh7fffffff : ((imp_r < 0) ? 32'sh80000000 : '0);
            state_r <= S_DMUL;
          end else begin
            state_r <= S_QW;
          end
        end
        S_QW: begin
          if (div_done) begin
            q_r     <= bwir_pkg::sat32(66'(div_quo));
            state_r <= S_DMUL;
          end
        end
        S_DMUL: begin
          // product lands in p_r; scale happens on the next pass
          p_r     <= prod;
          i_r     <= 2'd3;
          state_r <= S_BACC;
        end
        S_FIN: begin
          if (load) begin
            o_status_r  <= status_r;
            o_wall_r    <= (status_r == bwir_pkg::ST_NONE) ? bwir_pkg::WALL_NONE : job.wall;
            if (status_r == bwir_pkg::ST_IMPULSE) begin
              o_dlin_r <= {dl[2], dl1, dl[0]};
              o_dang_r <= dang_r;
            end else begin
              o_dlin_r <= '0;
              o_dang_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = o_status_r;
  assign out_wall   = o_wall_r;
  assign out_dlin_x = o_dlin_r[0];
  assign out_dlin_y = o_dlin_r[1];
  assign out_dlin_z = o_dlin_r[2];
  assign out_dang_x = o_dang_r[0];
  assign out_dang_y = o_dang_r[1];
  assign out_dang_z = o_dang_r[2];

endmodule

FILE: design/box_wall_impulse_response.sv
// Box wall impulse response, top level.
// Holds the configuration registers; joins bwir_front, bwir_fifo and bwir_back.
//
// Use: a body arrives on the in_ channel as a run of items: kind 0 with its
// translation and mass, kind 1 its velocity, kinds 2 to 4 the inverse inertia
// rows, then kind 5 vertices with in_final_vertex on the last. Kinds 6 and 7
// are taken and dropped. Each final vertex gives one item on the out_ channel.
// Body and vertex items are taken one a cycle while in_stall is low. The final
// vertex hands the body to a two-entry queue; the back end then works it out
// with up to three 64-step divisions on its one shared divider and the shared
// multiplier. While the queue has room the input keeps flowing; with two
// bodies queued in_stall rises until the back end retires one.
// A result waits in the output register while out_stall is high; the back end
// holds its finished job until the register frees.
// Configuration (cfg_we, cfg_index, cfg_wdata) must be written only while idle; the block does not enforce this.
// Reset is synchronous, active low: walls go to -10.0 and +10.0, restitution
// to 0.5, queue and contact state clear. Body data is unknown until written.
module box_wall_impulse_response (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_kind,
  input  logic signed [31:0]  in_vx,
  input  logic signed [31:0]  in_vy,
  input  logic signed [31:0]  in_vz,
  input  logic [30:0]         in_body_mass,
  input  logic                in_final_vertex,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [2:0]          out_wall,
  output logic signed [31:0]  out_dlin_x,
  output logic signed [31:0]  out_dlin_y,
  output logic signed [31:0]  out_dlin_z,
  output logic signed [31:0]  out_dang_x,
  output logic signed [31:0]  out_dang_y,
  output logic signed [31:0]  out_dang_z,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);

  `include "box_wall_impulse_response_macros.svh"

  bwir_pkg::fx_t [2:0] box_lo_r, box_hi_r;
  logic [16:0]         rest_r;
  logic                job_valid, job_ready, q_valid, q_pop;
  bwir_pkg::job_t      job_in, job_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_lo_r <= {3{-32'sd655360}};
      box_hi_r <= {3{32'sd655360}};
      rest_r   <= 17'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        bwir_pkg::CFG_MIN_X: box_lo_r[0] <= cfg_wdata;
        bwir_pkg::CFG_MAX_X: box_hi_r[0] <= cfg_wdata;
        bwir_pkg::CFG_MIN_Y: box_lo_r[1] <= cfg_wdata;
        bwir_pkg::CFG_MAX_Y: box_hi_r[1] <= cfg_wdata;
        bwir_pkg::CFG_MIN_Z: box_lo_r[2] <= cfg_wdata;
        bwir_pkg::CFG_MAX_Z: box_hi_r[2] <= cfg_wdata;
        bwir_pkg::CFG_REST:  rest_r      <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  bwir_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_vx           (in_vx),
    .in_vy           (in_vy),
    .in_vz           (in_vz),
    .in_body_mass    (in_body_mass),
    .in_final_vertex (in_final_vertex),
    .box_lo          (box_lo_r),
    .box_hi          (box_hi_r),
    .job_valid       (job_valid),
    .job_ready       (job_ready),
    .job             (job_in)
  );

  bwir_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_valid),
    .push_ready (job_ready),
    .push_data  (job_in),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (job_out)
  );

  bwir_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (q_valid),
    .job_pop     (q_pop),
    .job         (job_out),
    .restitution (rest_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_wall    (out_wall),
    .out_dlin_x  (out_dlin_x),
    .out_dlin_y  (out_dlin_y),
    .out_dlin_z  (out_dlin_z),
    .out_dang_x  (out_dang_x),
    .out_dang_y  (out_dang_y),
    .out_dang_z  (out_dang_z)
  );

  `BWIR_ASSERT_IMPL(a_push_room, job_valid, job_ready, "job pushed into full queue")
  `BWIR_ASSERT_IMPL(a_pop_nonempty, q_pop, q_valid, "job popped from empty queue")
  `BWIR_ASSERT_IMPL(a_no_contact_zero, out_valid && out_status == bwir_pkg::ST_NONE, out_wall == bwir_pkg::WALL_NONE && out_dlin_x == 0 && out_dlin_z == 0, "wall or delta without contact")
  `BWIR_ASSERT_IMPL(a_away_zero, out_valid && out_status != bwir_pkg::ST_IMPULSE, out_dang_x == 0 && out_dang_y == 0 && out_dang_z == 0 && out_dlin_y == 0, "delta without impulse")

endmodule

FILE: tb/box_wall_impulse_response_test.sv
// Self-checking testbench for box_wall_impulse_response: bodies go in as item runs,
// each final vertex is predicted in fixed point and checked against the out_ item.
// Depends on bwir_pkg and the block's RTL.
module box_wall_impulse_response_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]    status;
    logic [2:0]    wall;
    bwir_pkg::fx_t dlin [3];
    bwir_pkg::fx_t dang [3];
  } response_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_kind = bwir_pkg::KIND_POSE;
  logic signed [31:0] in_vx = '0, in_vy = '0, in_vz = '0;
  logic [30:0] in_body_mass = '0;
  logic in_final_vertex = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [2:0] out_wall;
  logic signed [31:0] out_dlin_x, out_dlin_y, out_dlin_z;
  logic signed [31:0] out_dang_x, out_dang_y, out_dang_z;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = bwir_pkg::CFG_MIN_X;
  logic [31:0] cfg_wdata = '0;

  box_wall_impulse_response dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint wall_lo [3];
  longint wall_hi [3];
  longint rest_coef;
  longint body_pos [3];
  longint body_vel [3];
  longint body_mass_q;
  longint inv_inertia_m [9];
  bit     touching;
  logic [2:0] touch_wall;
  longint touch_point [3];

  response_t pending_responses [$];
  int  mismatches = 0;
  int  items_sent = 0;
  int  stall_left = 0;
  int  idle_left = 0;
  bit  quiet = 1'b0;
  int  quiet_cycles = 0;

  localparam logic [2:0] MIN_WALLS [3] =
    '{bwir_pkg::WALL_XMIN, bwir_pkg::WALL_YMIN, bwir_pkg::WALL_ZMIN};
  localparam logic [2:0] MAX_WALLS [3] =
    '{bwir_pkg::WALL_XMAX, bwir_pkg::WALL_YMAX, bwir_pkg::WALL_ZMAX};
  localparam longint ONE_Q = longint'(1) << bwir_pkg::FRAC_BITS;

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint floor_q(longint x);
    return x >>> bwir_pkg::FRAC_BITS;
  endfunction

  function automatic response_t wall_response();
    response_t res;
    longint n [3], r [3], a [3], b [3], c [3], dl [3], da [3];
    longint vn, d, invm, denom, num, imp, q, vyn;
    int ax;
    res.status = bwir_pkg::ST_NONE;
    res.wall = bwir_pkg::WALL_NONE;
    for (int i = 0; i < 3; i++) begin
      res.dlin[i] = '0;
      res.dang[i] = '0;
    end
    if (!touching || touch_wall == bwir_pkg::WALL_NONE) return res;
    ax = (int'(touch_wall) - 1) / 2;
    n = '{0, 0, 0};
    n[ax] = touch_wall[0] ? 1 : -1;
    res.wall = touch_wall;
    vn = n[ax] * body_vel[ax];
    if (vn > 0) begin
      res.status = bwir_pkg::ST_AWAY;
      return res;
    end
    res.status = bwir_pkg::ST_IMPULSE;
    for (int i = 0; i < 3; i++) r[i] = clamp32(touch_point[i] - body_pos[i]);
    a[0] = clamp32(r[1] * n[2] - r[2] * n[1]);
    a[1] = clamp32(r[2] * n[0] - r[0] * n[2]);
    a[2] = clamp32(r[0] * n[1] - r[1] * n[0]);
    for (int i = 0; i < 3; i++)
      b[i] = clamp32(floor_q(inv_inertia_m[3*i] * a[0]) + floor_q(inv_inertia_m[3*i+1] * a[1])
                     + floor_q(inv_inertia_m[3*i+2] * a[2]));
    c[0] = floor_q(b[1] * r[2]) - floor_q(b[2] * r[1]);
    c[1] = floor_q(b[2] * r[0]) - floor_q(b[0] * r[2]);
    c[2] = floor_q(b[0] * r[1]) - floor_q(b[1] * r[0]);
    d = c[0] * n[0] + c[1] * n[1] + c[2] * n[2];
    invm = (body_mass_q != 0) ? (ONE_Q << bwir_pkg::FRAC_BITS) / body_mass_q
                              : 64'sd2147483647;
    denom = invm + d;
    num = -(ONE_Q + rest_coef) * vn;
    imp = (denom != 0) ? clamp32(num / denom) : 0;
    if (body_mass_q != 0) q = clamp32((imp * ONE_Q) / body_mass_q);
    else q = (imp > 0) ? 64'sd2147483647 : ((imp < 0) ? -64'sd2147483648 : 0);
    for (int i = 0; i < 3; i++) begin
      dl[i] = clamp32(q * n[i]);
      da[i] = clamp32(floor_q(imp * b[i]));
    end
    if (touch_wall == bwir_pkg::WALL_YMIN) begin
      vyn = body_vel[1] + dl[1];
      if (vyn > 0 && vyn * 10 < ONE_Q) dl[1] = clamp32(dl[1] - vyn);
    end
    for (int i = 0; i < 3; i++) begin
      res.dlin[i] = dl[i][31:0];
      res.dang[i] = da[i][31:0];
    end
    return res;
  endfunction

  function automatic void absorb_item(logic [2:0] kind, bwir_pkg::fx_t vx,
                                      bwir_pkg::fx_t vy, bwir_pkg::fx_t vz,
                                      logic [30:0] mass, logic fin);
    longint v [3];
    logic [2:0] w;
    v = '{longint'(vx), longint'(vy), longint'(vz)};
    case (kind)
      bwir_pkg::KIND_POSE: begin
        body_pos = v;
        body_mass_q = longint'(mass);
        touching = 1'b0;
        touch_wall = bwir_pkg::WALL_NONE;
        touch_point = '{0, 0, 0};
      end
      bwir_pkg::KIND_VEL: body_vel = v;
      bwir_pkg::KIND_INV0, bwir_pkg::KIND_INV1, bwir_pkg::KIND_INV2: begin
        for (int i = 0; i < 3; i++)
          inv_inertia_m[3 * (int'(kind) - int'(bwir_pkg::KIND_INV0)) + i] = v[i];
      end
      bwir_pkg::KIND_VERT: begin
        if (!touching) begin
          w = bwir_pkg::WALL_NONE;
          for (int i = 0; i < 3 && w == bwir_pkg::WALL_NONE; i++) begin
            if (v[i] <= wall_lo[i]) w = MIN_WALLS[i];
            else if (v[i] >= wall_hi[i]) w = MAX_WALLS[i];
          end
          if (w != bwir_pkg::WALL_NONE) begin
            touching = 1'b1;
            touch_wall = w;
            touch_point = v;
          end
        end
        if (fin) begin
          pending_responses.insert(pending_responses.size(), wall_response());
          touching = 1'b0;
          touch_wall = bwir_pkg::WALL_NONE;
          touch_point = '{0, 0, 0};
        end
      end
      default: ;
    endcase
  endfunction

  // receiver stall bursts
  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    response_t e;
    bwir_pkg::fx_t got_l [3], got_a [3];
    bit bad;
    if (rst_n && out_valid && !out_stall) begin
      got_l = '{out_dlin_x, out_dlin_y, out_dlin_z};
      got_a = '{out_dang_x, out_dang_y, out_dang_z};
      if (pending_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: status %0d wall %0d",
                                       out_status, out_wall);
      end else begin
        e = pending_responses.pop_front();
        bad = (e.status !== out_status) || (e.wall !== out_wall);
        for (int i = 0; i < 3; i++)
          if (e.dlin[i] !== got_l[i] || e.dang[i] !== got_a[i]) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp st %0d w %0d dl %0d %0d %0d da %0d %0d %0d", e.status,
                     e.wall, e.dlin[0], e.dlin[1], e.dlin[2], e.dang[0], e.dang[1], e.dang[2]);
            $display("          got st %0d w %0d dl %0d %0d %0d da %0d %0d %0d", out_status,
                     out_wall, got_l[0], got_l[1], got_l[2], got_a[0], got_a[1], got_a[2]);
          end
        end
      end
    end
  end

  // watchdog: cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("** box_wall_impulse_response: FAILED **");
      $finish;
    end
  end

  task automatic send_item(logic [2:0] kind, bwir_pkg::fx_t vx, bwir_pkg::fx_t vy,
                           bwir_pkg::fx_t vz, logic [30:0] mass, logic fin);
    if (!quiet && idle_left == 0 && $urandom_range(0, 7) == 0) idle_left = $urandom_range(1, 14);
    if (!quiet && idle_left > 0) begin
      in_valid <= 1'b0;
      repeat (idle_left) @(posedge clk);
      idle_left = 0;
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_vx <= vx;
    in_vy <= vy;
    in_vz <= vz;
    in_body_mass <= mass;
    in_final_vertex <= fin;
    do @(posedge clk); while (in_stall);
    absorb_item(kind, vx, vy, vz, mass, fin);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_responses.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bwir_pkg::CFG_MIN_X: wall_lo[0] = longint'($signed(data));
      bwir_pkg::CFG_MAX_X: wall_hi[0] = longint'($signed(data));
      bwir_pkg::CFG_MIN_Y: wall_lo[1] = longint'($signed(data));
      bwir_pkg::CFG_MAX_Y: wall_hi[1] = longint'($signed(data));
      bwir_pkg::CFG_MIN_Z: wall_lo[2] = longint'($signed(data));
      bwir_pkg::CFG_MAX_Z: wall_hi[2] = longint'($signed(data));
      bwir_pkg::CFG_REST:  rest_coef = longint'(data[16:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_box(bwir_pkg::fx_t lo, bwir_pkg::fx_t hi, logic [16:0] e);
    drain();
    write_reg(bwir_pkg::CFG_MIN_X, lo);
    write_reg(bwir_pkg::CFG_MAX_X, hi);
    write_reg(bwir_pkg::CFG_MIN_Y, lo);
    write_reg(bwir_pkg::CFG_MAX_Y, hi);
    write_reg(bwir_pkg::CFG_MIN_Z, lo);
    write_reg(bwir_pkg::CFG_MAX_Z, hi);
    write_reg(bwir_pkg::CFG_REST, {15'd0, e});
  endtask

  function automatic bwir_pkg::fx_t pick_coord(int axis);
    longint span, lo, hi;
    lo = wall_lo[axis];
    hi = wall_hi[axis];
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return bwir_pkg::fx_t'(clamp32(lo + $signed($urandom_range(0, 6)) - 3));
      2: return bwir_pkg::fx_t'(clamp32(hi + $signed($urandom_range(0, 6)) - 3));
      default: begin
        span = hi - lo;
        if (span <= 0) return $urandom;
        return bwir_pkg::fx_t'(lo + (longint'({$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff)
                                     % span));
      end
    endcase
  endfunction

  function automatic bwir_pkg::fx_t pick_small(int bits);
    if ($urandom_range(0, 15) == 0) return $urandom;
    return bwir_pkg::fx_t'($signed($urandom_range(0, 2 ** bits)) - 2 ** (bits - 1));
  endfunction

  function automatic logic [30:0] pick_mass();
    case ($urandom_range(0, 9))
      0: return 31'd1;
      1: return 31'($urandom);
      2: return 31'h7fffffff;
      default: return 31'($urandom_range(1 << 10, 1 << 22));
    endcase
  endfunction

  task automatic send_setup();
    send_item(bwir_pkg::KIND_POSE, pick_coord(0), pick_coord(1), pick_coord(2), pick_mass(),
              1'($urandom));
    send_item(bwir_pkg::KIND_VEL, pick_small(20), pick_small(20), pick_small(20),
              31'($urandom), 1'($urandom));
    for (int k = 0; k < 3; k++)
      send_item(3'(bwir_pkg::KIND_INV0 + k), pick_small(18), pick_small(18), pick_small(18),
                31'($urandom), 1'b0);
  endtask

  task automatic send_vertices(int count);
    for (int k = 0; k < count; k++)
      send_item(bwir_pkg::KIND_VERT, pick_coord(0), pick_coord(1), pick_coord(2),
                31'($urandom), k == count - 1);
  endtask

  task automatic test_defaults();
    // resting on the floor: contact at the translation, unit mass, falling at 0.1
    send_item(bwir_pkg::KIND_POSE, 0, -32'sd655360, 0, 31'd65536, 1'b0);
    send_item(bwir_pkg::KIND_VEL, 0, -32'sd6554, 0, '0, 1'b0);
    send_item(bwir_pkg::KIND_INV0, 32'sd65536, 0, 0, '0, 1'b0);
    send_item(bwir_pkg::KIND_INV1, 0, 32'sd65536, 0, '0, 1'b0);
    send_item(bwir_pkg::KIND_INV2, 0, 0, 32'sd65536, '0, 1'b0);
    send_item(bwir_pkg::KIND_VERT, 0, -32'sd655360, 0, '0, 1'b1);
    // one vertex per wall, each with a spun-off contact point
    for (int w = 0; w < 6; w++) begin
      bwir_pkg::fx_t p [3];
      p = '{32'sd65536, -32'sd32768, 32'sd16384};
      p[w / 2] = (w % 2) ? 32'sd700000 : -32'sd700000;
      send_item(bwir_pkg::KIND_VEL, (w % 2) ? 32'sd90000 : -32'sd90000, 32'sd1000,
                -32'sd90000, '0, 1'b0);
      send_item(bwir_pkg::KIND_VERT, p[0], p[1], p[2], '0, 1'b1);
    end
    // no contact, moving away, unused kinds, stray flag
    send_item(bwir_pkg::KIND_VERT, 0, 0, 0, '0, 1'b1);
    send_item(bwir_pkg::KIND_VEL, 32'sd5000, 32'sd5000, 32'sd5000, '0, 1'b1);
    send_item(bwir_pkg::KIND_VERT, -32'sd655360, 0, 0, '0, 1'b1);
    send_item(3'd6, $urandom, $urandom, $urandom, 31'($urandom), 1'b1);
    send_item(3'd7, $urandom, $urandom, $urandom, 31'($urandom), 1'b1);
    // zero mass, then pose reset in the middle of a vertex run
    send_item(bwir_pkg::KIND_POSE, 0, 0, 0, '0, 1'b0);
    send_item(bwir_pkg::KIND_VEL, -32'sd70000, 0, 0, '0, 1'b0);
    send_item(bwir_pkg::KIND_VERT, -32'sd700000, 32'sd100, 0, '0, 1'b1);
    send_item(bwir_pkg::KIND_VERT, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, '0, 1'b0);
    send_item(bwir_pkg::KIND_POSE, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
              31'h7fffffff, 1'b0);
    send_item(bwir_pkg::KIND_VERT, 32'sh80000000, 32'sh80000000, 32'sh80000000, '0, 1'b1);
    send_item(bwir_pkg::KIND_VERT, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, '0, 1'b1);
  endtask

  task automatic run_bodies(int goal);
    int start;
    start = items_sent;
    while (items_sent - start < goal) begin
      case ($urandom_range(0, 9))
        0: send_item(3'(6 + $urandom_range(0, 1)), $urandom, $urandom, $urandom,
                     31'($urandom), 1'($urandom));
        1: send_vertices($urandom_range(1, 4));
        2: send_item(bwir_pkg::KIND_VEL, pick_small(20), pick_small(20), pick_small(20), '0,
                     1'($urandom));
        default: begin
          send_setup();
          send_vertices($urandom_range(1, 6));
        end
      endcase
    end
  endtask

  task automatic test_extreme_box();
    set_box(32'sh80000000, 32'sh7fffffff, 17'd0);
    run_bodies(60);
    set_box(-32'sd65536, 32'sd65536, 17'd65536);
    run_bodies(120);
  endtask

  task automatic test_random_boxes();
    for (int k = 0; k < 4; k++) begin
      drain();
      for (int i = 0; i < 6; i++)
        write_reg(3'(bwir_pkg::CFG_MIN_X + i), (i % 2) ? $urandom_range(1 << 14, 1 << 22)
                                                       : -$urandom_range(1 << 14, 1 << 22));
      write_reg(bwir_pkg::CFG_REST, $urandom_range(0, 65536));
      run_bodies(250);
    end
  endtask

  task automatic test_no_idling();
    set_box(-32'sd655360, 32'sd655360, 17'd32768);
    quiet = 1'b1;
    run_bodies(400);
  endtask

  initial begin
    wall_lo = '{-655360, -655360, -655360};
    wall_hi = '{655360, 655360, 655360};
    rest_coef = 32768;
    body_pos = '{0, 0, 0};
    body_vel = '{0, 0, 0};
    body_mass_q = 0;
    inv_inertia_m = '{default: 0};
    touching = 1'b0;
    touch_wall = bwir_pkg::WALL_NONE;
    touch_point = '{0, 0, 0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_extreme_box();
    test_random_boxes();
    test_no_idling();
    in_valid <= 1'b0;
    wait (pending_responses.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("** box_wall_impulse_response: PASSED **");
    end else begin
      $display("** box_wall_impulse_response: FAILED **");
    end
    $finish;
  end
endmodule
